// File: sv/dcis_pkg.sv
// ----------------------------------------------------------------------------
// dcis_pkg
// Shared types, sizes, codes and digit tables of the decimal computer step.
// ----------------------------------------------------------------------------
package dcis_pkg;

  localparam int MEM_WORDS    = 100;
  localparam int REG_COUNT    = 10;
  localparam int AW           = $clog2(MEM_WORDS);
  localparam int RW           = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;

  localparam int WORD_W       = 15;
  localparam int ADDR_FIELD_W = 7;
  localparam int CHAR_W       = 8;
  localparam int EV_W         = 3;
  localparam int MAG_W        = 14;
  localparam int DIGIT_W      = 4;
  localparam int MM_W         = 7;

  localparam int WORD_MAX     = 9999;
  localparam int MOD_BASE     = 10000;
  localparam int MM_SPAN      = 100;
  localparam int DIGIT_BASE   = 10;

  // magnitude / 100 as a multiply by a scaled reciprocal, exact below 10000
  localparam int Q100_MUL     = 5243;
  localparam int Q100_SHIFT   = 19;
  localparam int PROD_W       = 28;

  typedef logic signed [WORD_W-1:0] word_t;

  typedef enum logic [EV_W-1:0] {
    EV_NONE   = 3'd0,
    EV_PRINT  = 3'd1,
    EV_HALT   = 3'd2,
    EV_HALTED = 3'd3,
    EV_READ   = 3'd4
  } ev_t;

  localparam logic [DIGIT_W-1:0] OP_HALT  = 4'd0;
  localparam logic [DIGIT_W-1:0] OP_LOAD  = 4'd1;
  localparam logic [DIGIT_W-1:0] OP_STORE = 4'd2;
  localparam logic [DIGIT_W-1:0] OP_ADD   = 4'd3;
  localparam logic [DIGIT_W-1:0] OP_NEG   = 4'd4;
  localparam logic [DIGIT_W-1:0] OP_LDI   = 4'd5;
  localparam logic [DIGIT_W-1:0] OP_ADDI  = 4'd6;
  localparam logic [DIGIT_W-1:0] OP_JMP   = 4'd7;
  localparam logic [DIGIT_W-1:0] OP_BPOS  = 4'd8;
  localparam logic [DIGIT_W-1:0] OP_IO    = 4'd9;

  localparam logic [DIGIT_W-1:0] SUB_READ   = 4'd0;
  localparam logic [DIGIT_W-1:0] SUB_PRINT  = 4'd1;
  localparam logic [DIGIT_W-1:0] SUB_STRING = 4'd2;

  typedef struct packed {
    logic [DIGIT_W-1:0] op;
    logic [DIGIT_W-1:0] sub;
    logic               neg;
    logic [MM_W-1:0]    mm;
    word_t              ra;
    word_t              rb;
    word_t              mdat;
    logic [CHAR_W-1:0]  chr;
  } alu_in_t;

  typedef struct packed {
    logic              reg_we;
    word_t             reg_wdata;
    logic              mem_we;
    logic              jump;
    logic              advance;
    logic              halt;
    logic              str_start;
    ev_t               ev;
    logic [CHAR_W-1:0] ch;
    word_t             reg_out;
  } alu_out_t;

  // two low digits of a word -> memory address
  function automatic logic [AW-1:0] addr_mod(input logic [MM_W-1:0] mm);
    logic [AW-1:0] res;
    res = '0;
    for (int i = 0; i < MM_SPAN; i++) begin
      if (mm == MM_W'(i)) res = AW'(i % MEM_WORDS);
    end
    return res;
  endfunction

  // hundreds digit -> register index
  function automatic logic [RW-1:0] reg_mod(input logic [DIGIT_W-1:0] d);
    logic [RW-1:0] res;
    res = '0;
    for (int i = 0; i < DIGIT_BASE; i++) begin
      if (d == DIGIT_W'(i)) res = RW'(i % REG_COUNT);
    end
    return res;
  endfunction

  // value 0..99 -> {tens, ones}
  function automatic logic [2*DIGIT_W-1:0] split_digits(input logic [MM_W-1:0] q);
    logic [2*DIGIT_W-1:0] res;
    res = '0;
    for (int i = 0; i < MM_SPAN; i++) begin
      if (q == MM_W'(i)) res = {DIGIT_W'(i / DIGIT_BASE), DIGIT_W'(i % DIGIT_BASE)};
    end
    return res;
  endfunction

endpackage

// File: sv/dcis_in_if.sv
// ----------------------------------------------------------------------------
// dcis_in_if
// Input channel: one word per load or step request.
// ----------------------------------------------------------------------------
interface dcis_in_if;
  logic                                valid;
  logic                                ready;
  logic                                kind;
  logic [dcis_pkg::ADDR_FIELD_W-1:0]   load_addr;
  dcis_pkg::word_t                     load_value;
  logic [dcis_pkg::CHAR_W-1:0]         char_in;

  modport source (output valid, kind, load_addr, load_value, char_in, input ready);
  modport sink   (input valid, kind, load_addr, load_value, char_in, output ready);
endinterface

// File: sv/dcis_out_if.sv
// ----------------------------------------------------------------------------
// dcis_out_if
// Result channel: one word per accepted request.
// ----------------------------------------------------------------------------
interface dcis_out_if;
  logic                              valid;
  logic                              ready;
  dcis_pkg::ev_t                     event_res;
  logic [dcis_pkg::CHAR_W-1:0]       char_out;
  logic [dcis_pkg::ADDR_FIELD_W-1:0] pc_now;
  dcis_pkg::word_t                   instr_word;
  dcis_pkg::word_t                   reg_written;
  logic                              halted_flag;

  modport source (output valid, event_res, char_out, pc_now, instr_word, reg_written,
                  halted_flag, input ready);
  modport sink   (input valid, event_res, char_out, pc_now, instr_word, reg_written,
                  halted_flag, output ready);
endinterface

// File: sv/dcis_alu.sv
// ----------------------------------------------------------------------------
// dcis_alu
// Execute stage: decides register and memory write-back, flow and events.
// ----------------------------------------------------------------------------
module dcis_alu (
  input  dcis_pkg::alu_in_t  a_in,
  output dcis_pkg::alu_out_t a_out
);

  localparam logic signed [dcis_pkg::WORD_W:0] BASE_S =
    (dcis_pkg::WORD_W + 1)'(dcis_pkg::MOD_BASE);

  dcis_pkg::word_t imm;

  // truncating remainder by 10000 of a sum that stays below 20000 in size
  function automatic dcis_pkg::word_t wrap_sum(input dcis_pkg::word_t x,
                                                input dcis_pkg::word_t y);
    logic signed [dcis_pkg::WORD_W:0] s;
    s = (dcis_pkg::WORD_W + 1)'(x) + (dcis_pkg::WORD_W + 1)'(y);
    if (s >= BASE_S) begin
      s = s - BASE_S;
    end else if (s <= -BASE_S) begin
      s = s + BASE_S;
    end
    return s[dcis_pkg::WORD_W-1:0];
  endfunction

  always_comb begin
    imm = dcis_pkg::word_t'({{(dcis_pkg::WORD_W - dcis_pkg::MM_W){1'b0}}, a_in.mm});
    if (a_in.neg) imm = -imm;
  end

  always_comb begin
    a_out           = '0;
    a_out.reg_wdata = a_in.ra;
    a_out.ev        = dcis_pkg::EV_NONE;
    unique case (a_in.op)
      dcis_pkg::OP_HALT: begin
        a_out.halt = 1'b1;
        a_out.ev   = dcis_pkg::EV_HALT;
      end
      dcis_pkg::OP_LOAD: begin
        a_out.reg_we    = 1'b1;
        a_out.reg_wdata = a_in.mdat;
        a_out.advance   = 1'b1;
      end
      dcis_pkg::OP_STORE: begin
        a_out.mem_we  = 1'b1;
        a_out.advance = 1'b1;
      end
      dcis_pkg::OP_ADD: begin
        a_out.reg_we    = 1'b1;
        a_out.reg_wdata = wrap_sum(a_in.ra, a_in.mdat);
        a_out.advance   = 1'b1;
      end
      dcis_pkg::OP_NEG: begin
        a_out.reg_we    = 1'b1;
        a_out.reg_wdata = -a_in.ra;
        a_out.advance   = 1'b1;
      end
      dcis_pkg::OP_LDI: begin
        a_out.reg_we    = 1'b1;
        a_out.reg_wdata = imm;
        a_out.advance   = 1'b1;
      end
      dcis_pkg::OP_ADDI: begin
        a_out.reg_we    = 1'b1;
        a_out.reg_wdata = wrap_sum(a_in.ra, imm);
        a_out.advance   = 1'b1;
      end
      dcis_pkg::OP_JMP: begin
        a_out.jump = 1'b1;
      end
      dcis_pkg::OP_BPOS: begin
        if (!a_in.ra[dcis_pkg::WORD_W-1] && (a_in.ra != '0)) begin
          a_out.jump = 1'b1;
        end else begin
          a_out.advance = 1'b1;
        end
      end
      dcis_pkg::OP_IO: begin
        unique case (a_in.sub)
          dcis_pkg::SUB_READ: begin
            a_out.reg_we    = 1'b1;
            a_out.reg_wdata = dcis_pkg::word_t'(
              {{(dcis_pkg::WORD_W - dcis_pkg::CHAR_W){1'b0}}, a_in.chr});
            a_out.ev        = dcis_pkg::EV_READ;
            a_out.advance   = 1'b1;
          end
          dcis_pkg::SUB_PRINT: begin
            a_out.ch      = a_in.rb[dcis_pkg::CHAR_W-1:0];
            a_out.ev      = dcis_pkg::EV_PRINT;
            a_out.advance = 1'b1;
          end
          dcis_pkg::SUB_STRING: begin
            a_out.str_start = 1'b1;
          end
          default: begin
            a_out.advance = 1'b1;
          end
        endcase
      end
      default: begin
        a_out.advance = 1'b1;
      end
    endcase
    a_out.reg_out = a_out.reg_we ? a_out.reg_wdata : a_in.ra;
  end

endmodule

// File: sv/decimal_computer_instruction_step.sv
// ----------------------------------------------------------------------------
// decimal_computer_instruction_step
// A simple decimal computer that loads memory words and runs one instruction
// per request word. Main memory (100 signed four-digit words) and the ten
// registers sit in synchronous memories with registered reads and read as
// zero until written, so reset takes effect at once with no clearing pass.
// Every request word gives exactly one result word. A load word or a step on
// a halted machine goes from accept straight to the result state; an
// instruction step runs accept and fetch read, magnitude and hundreds split,
// digit split, operand read of memory and registers, execute and write back,
// and result, with a look-ahead read before the result when a print string
// instruction prints its first character and must look at the next word to
// see whether the string ends; a print string step that continues a string
// reads its character and may look ahead in the same way. A result that is
// not taken holds the sequencer in its result state. A new request word is
// taken whenever the sequencer is idle, even while the last result word
// still waits in the output register.
// ----------------------------------------------------------------------------
module decimal_computer_instruction_step (
  input  logic        clk,
  input  logic        rst_n,
  dcis_in_if.sink     in_chan,
  dcis_out_if.source  out_chan
);

  localparam int AW     = dcis_pkg::AW;
  localparam int RW     = dcis_pkg::RW;
  localparam int CW     = dcis_pkg::CHAR_W;
  localparam int MAG_W  = dcis_pkg::MAG_W;
  localparam int MM_W   = dcis_pkg::MM_W;
  localparam int DW     = dcis_pkg::DIGIT_W;

  localparam dcis_pkg::word_t WORD_HI = dcis_pkg::WORD_W'(dcis_pkg::WORD_MAX);
  localparam dcis_pkg::word_t WORD_LO = dcis_pkg::WORD_W'(-dcis_pkg::WORD_MAX);

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_FETCH = 8'b0000_0010,
    ST_DEC   = 8'b0000_0100,
    ST_ISSUE = 8'b0000_1000,
    ST_EXEC  = 8'b0001_0000,
    ST_STR0  = 8'b0010_0000,
    ST_STR1  = 8'b0100_0000,
    ST_RESP  = 8'b1000_0000
  } state_t;

  // sequencer and architectural state
  state_t               st_r,      st_nxt;
  logic [AW-1:0]        pc_r,      pc_nxt;
  logic [AW-1:0]        sp_r,      sp_nxt;
  logic [AW-1:0]        addr_r,    addr_nxt;
  logic [RW-1:0]        r_r,       r_nxt;
  dcis_pkg::word_t      ir_r,      ir_nxt;
  logic                 halted_r,  halted_nxt;
  logic                 str_act_r, str_act_nxt;

  // decode pipeline of the current word
  logic [CW-1:0]        chr_r,     chr_nxt;
  logic                 neg_r,     neg_nxt;
  logic [MAG_W-1:0]     mag_r,     mag_nxt;
  logic [MM_W-1:0]      q100_r,    q100_nxt;
  logic [MM_W-1:0]      mm_r,      mm_nxt;
  logic [DW-1:0]        op_r,      op_nxt;
  logic [DW-1:0]        dig_r,     dig_nxt;

  // result being built
  dcis_pkg::ev_t        res_ev_r,  res_ev_nxt;
  logic [CW-1:0]        res_ch_r,  res_ch_nxt;
  logic [AW-1:0]        res_pc_r,  res_pc_nxt;
  dcis_pkg::word_t      res_reg_r, res_reg_nxt;

  // output register
  logic                 out_valid_r, out_valid_nxt;
  dcis_pkg::ev_t        out_ev_r,    out_ev_nxt;
  logic [CW-1:0]        out_ch_r,    out_ch_nxt;
  logic [dcis_pkg::ADDR_FIELD_W-1:0] out_pc_r, out_pc_nxt;
  dcis_pkg::word_t      out_iw_r,    out_iw_nxt;
  dcis_pkg::word_t      out_reg_r,   out_reg_nxt;
  logic                 out_halt_r,  out_halt_nxt;

  // main memory
  dcis_pkg::word_t          mem [dcis_pkg::MEM_WORDS];
  logic [dcis_pkg::MEM_WORDS-1:0] mem_vld_r;
  dcis_pkg::word_t          mem_q_r;
  logic                     mem_qv_r;
  logic                     mem_we, mem_re;
  logic [AW-1:0]            mem_waddr, mem_raddr;
  dcis_pkg::word_t          mem_wdata, mem_rd;

  // register file: port A at a chosen index, port B fixed on register 0
  dcis_pkg::word_t          rf [dcis_pkg::REG_COUNT];
  logic [dcis_pkg::REG_COUNT-1:0] rf_vld_r;
  dcis_pkg::word_t          rfa_q_r, rfb_q_r;
  logic                     rfa_qv_r, rfb_qv_r;
  logic                     rf_we, rfa_re;
  logic [RW-1:0]            rf_waddr, rfa_raddr;
  dcis_pkg::word_t          rf_wdata, rf_a, rf_b;

  // helpers
  dcis_pkg::alu_in_t        alu_in;
  dcis_pkg::alu_out_t       alu_out;
  dcis_pkg::word_t          load_sat, fetch_neg;
  logic [MAG_W-1:0]         fetch_mag, hund;
  logic [dcis_pkg::PROD_W-1:0] q_prod;
  logic [AW:0]              pc_sum, p_sum;
  logic [AW-1:0]            pc_inc, str_p;
  logic                     str_last, str_go, load_ok, in_acc;

  assign mem_rd = mem_qv_r ? mem_q_r : '0;
  assign rf_a   = rfa_qv_r ? rfa_q_r : '0;
  assign rf_b   = rfb_qv_r ? rfb_q_r : '0;

  assign in_acc        = in_chan.valid && in_chan.ready;
  assign in_chan.ready = (st_r == ST_IDLE);

  // clip a load word to four digits
  always_comb begin
    load_sat = in_chan.load_value;
    if (in_chan.load_value > WORD_HI) begin
      load_sat = WORD_HI;
    end else if (in_chan.load_value < WORD_LO) begin
      load_sat = WORD_LO;
    end
  end
  assign load_ok = (in_chan.load_addr < dcis_pkg::ADDR_FIELD_W'(dcis_pkg::MEM_WORDS));

  // magnitude and hundreds of the fetched word
  assign fetch_neg = -mem_rd;
  assign fetch_mag = mem_rd[dcis_pkg::WORD_W-1] ? fetch_neg[MAG_W-1:0] : mem_rd[MAG_W-1:0];
  assign q_prod    = dcis_pkg::PROD_W'(fetch_mag) * dcis_pkg::PROD_W'(dcis_pkg::Q100_MUL);
  assign hund      = MAG_W'(q100_r) * MAG_W'(dcis_pkg::MM_SPAN);

  // wrap the pc at the end of memory; a string pointer there ends the string
  assign pc_sum   = {1'b0, pc_r} + 1'b1;
  assign pc_inc   = (pc_sum == (AW + 1)'(dcis_pkg::MEM_WORDS)) ? '0 : pc_sum[AW-1:0];
  assign str_p    = (st_r == ST_STR0) ? sp_r : addr_r;
  assign p_sum    = {1'b0, str_p} + 1'b1;
  assign str_last = (p_sum == (AW + 1)'(dcis_pkg::MEM_WORDS));

  always_comb begin
    alu_in      = '0;
    alu_in.op   = op_r;
    alu_in.sub  = dig_r;
    alu_in.neg  = neg_r;
    alu_in.mm   = mm_r;
    alu_in.ra   = rf_a;
    alu_in.rb   = rf_b;
    alu_in.mdat = mem_rd;
    alu_in.chr  = chr_r;
  end

  dcis_alu u_alu (
    .a_in  (alu_in),
    .a_out (alu_out)
  );

  assign str_go = ((st_r == ST_EXEC) && alu_out.str_start) || (st_r == ST_STR0);

  // sequencer
  always_comb begin
    st_nxt        = st_r;
    pc_nxt        = pc_r;
    sp_nxt        = sp_r;
    addr_nxt      = addr_r;
    r_nxt         = r_r;
    ir_nxt        = ir_r;
    halted_nxt    = halted_r;
    str_act_nxt   = str_act_r;
    chr_nxt       = chr_r;
    neg_nxt       = neg_r;
    mag_nxt       = mag_r;
    q100_nxt      = q100_r;
    mm_nxt        = mm_r;
    op_nxt        = op_r;
    dig_nxt       = dig_r;
    res_ev_nxt    = res_ev_r;
    res_ch_nxt    = res_ch_r;
    res_pc_nxt    = res_pc_r;
    res_reg_nxt   = res_reg_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    out_ev_nxt    = out_ev_r;
    out_ch_nxt    = out_ch_r;
    out_pc_nxt    = out_pc_r;
    out_iw_nxt    = out_iw_r;
    out_reg_nxt   = out_reg_r;
    out_halt_nxt  = out_halt_r;

    mem_we    = 1'b0;
    mem_waddr = addr_r;
    mem_wdata = rf_a;
    mem_re    = 1'b0;
    mem_raddr = pc_r;
    rf_we     = 1'b0;
    rf_waddr  = r_r;
    rf_wdata  = alu_out.reg_wdata;
    rfa_re    = 1'b0;
    rfa_raddr = r_r;

    unique case (st_r)
      ST_IDLE: begin
        if (in_acc) begin
          res_pc_nxt  = pc_r;
          chr_nxt     = in_chan.char_in;
          res_ev_nxt  = dcis_pkg::EV_NONE;
          res_ch_nxt  = '0;
          res_reg_nxt = '0;
          if (!in_chan.kind) begin
            // load word: write and answer straight away
            if (load_ok) begin
              mem_we    = 1'b1;
              mem_waddr = in_chan.load_addr[AW-1:0];
              mem_wdata = load_sat;
            end
            st_nxt = ST_RESP;
          end else if (halted_r) begin
            res_ev_nxt = dcis_pkg::EV_HALTED;
            st_nxt     = ST_RESP;
          end else if (str_act_r) begin
            // carry on with the string: no new fetch
            mem_re    = 1'b1;
            mem_raddr = sp_r;
            rfa_re    = 1'b1;
            rfa_raddr = r_r;
            st_nxt    = ST_STR0;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = pc_r;
            st_nxt    = ST_FETCH;
          end
        end
      end
      ST_FETCH: begin
        ir_nxt   = mem_rd;
        neg_nxt  = mem_rd[dcis_pkg::WORD_W-1];
        mag_nxt  = fetch_mag;
        q100_nxt = q_prod[dcis_pkg::Q100_SHIFT +: MM_W];
        st_nxt   = ST_DEC;
      end
      ST_DEC: begin
        mm_nxt            = MM_W'(mag_r - hund);
        {op_nxt, dig_nxt} = dcis_pkg::split_digits(q100_r);
        st_nxt            = ST_ISSUE;
      end
      ST_ISSUE: begin
        r_nxt     = dcis_pkg::reg_mod(dig_r);
        addr_nxt  = dcis_pkg::addr_mod(mm_r);
        mem_re    = 1'b1;
        mem_raddr = addr_nxt;
        rfa_re    = 1'b1;
        rfa_raddr = r_nxt;
        st_nxt    = ST_EXEC;
      end
      ST_EXEC: begin
        res_reg_nxt = alu_out.reg_out;
        res_ev_nxt  = alu_out.ev;
        res_ch_nxt  = alu_out.ch;
        rf_we       = alu_out.reg_we;
        mem_we      = alu_out.mem_we;
        if (alu_out.halt)    halted_nxt = 1'b1;
        if (alu_out.jump)    pc_nxt     = addr_r;
        if (alu_out.advance) pc_nxt     = pc_inc;
        st_nxt = ST_RESP;
      end
      ST_STR0: begin
        res_reg_nxt = rf_a;
        st_nxt      = ST_RESP;
      end
      ST_STR1: begin
        // look-ahead word decides whether the string goes on
        if (mem_rd == '0) begin
          str_act_nxt = 1'b0;
          pc_nxt      = pc_inc;
        end else begin
          str_act_nxt = 1'b1;
        end
        st_nxt = ST_RESP;
      end
      ST_RESP: begin
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt = 1'b1;
          out_ev_nxt    = res_ev_r;
          out_ch_nxt    = res_ch_r;
          out_pc_nxt    = dcis_pkg::ADDR_FIELD_W'(res_pc_r);
          out_iw_nxt    = ir_r;
          out_reg_nxt   = res_reg_r;
          out_halt_nxt  = halted_r;
          st_nxt        = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase

    // one string character: a zero word ends the string; else print it, then end or read ahead
    if (str_go) begin
      if (mem_rd == '0) begin
        str_act_nxt = 1'b0;
        pc_nxt      = pc_inc;
        res_ev_nxt  = dcis_pkg::EV_NONE;
        res_ch_nxt  = '0;
      end else begin
        res_ev_nxt = dcis_pkg::EV_PRINT;
        res_ch_nxt = mem_rd[CW-1:0];
        if (str_last) begin
          str_act_nxt = 1'b0;
          pc_nxt      = pc_inc;
        end else begin
          sp_nxt    = p_sum[AW-1:0];
          mem_re    = 1'b1;
          mem_raddr = p_sum[AW-1:0];
          st_nxt    = ST_STR1;
        end
      end
    end
  end

  // main memory: one write and one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_q_r <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mem_vld_r <= '0;
      mem_qv_r  <= 1'b0;
    end else begin
      if (mem_we) begin
        mem_vld_r[mem_waddr] <= 1'b1;
      end
      if (mem_re) begin
        mem_qv_r <= mem_vld_r[mem_raddr];
      end
    end
  end

  // register file
  always_ff @(posedge clk) begin
    if (rf_we) begin
      rf[rf_waddr] <= rf_wdata;
    end
    if (rfa_re) begin
      rfa_q_r <= rf[rfa_raddr];
    end
    rfb_q_r <= rf[0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rf_vld_r <= '0;
      rfa_qv_r <= 1'b0;
      rfb_qv_r <= 1'b0;
    end else begin
      if (rf_we) begin
        rf_vld_r[rf_waddr] <= 1'b1;
      end
      if (rfa_re) begin
        rfa_qv_r <= rf_vld_r[rfa_raddr];
      end
      rfb_qv_r <= rf_vld_r[0];
    end
  end

  // control and architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      pc_r        <= '0;
      sp_r        <= '0;
      ir_r        <= '0;
      halted_r    <= 1'b0;
      str_act_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      pc_r        <= pc_nxt;
      sp_r        <= sp_nxt;
      ir_r        <= ir_nxt;
      halted_r    <= halted_nxt;
      str_act_r   <= str_act_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload: no reset
  always_ff @(posedge clk) begin
    addr_r     <= addr_nxt;
    r_r        <= r_nxt;
    chr_r      <= chr_nxt;
    neg_r      <= neg_nxt;
    mag_r      <= mag_nxt;
    q100_r     <= q100_nxt;
    mm_r       <= mm_nxt;
    op_r       <= op_nxt;
    dig_r      <= dig_nxt;
    res_ev_r   <= res_ev_nxt;
    res_ch_r   <= res_ch_nxt;
    res_pc_r   <= res_pc_nxt;
    res_reg_r  <= res_reg_nxt;
    out_ev_r   <= out_ev_nxt;
    out_ch_r   <= out_ch_nxt;
    out_pc_r   <= out_pc_nxt;
    out_iw_r   <= out_iw_nxt;
    out_reg_r  <= out_reg_nxt;
    out_halt_r <= out_halt_nxt;
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.event_res   = out_ev_r;
  assign out_chan.char_out    = out_ch_r;
  assign out_chan.pc_now      = out_pc_r;
  assign out_chan.instr_word  = out_iw_r;
  assign out_chan.reg_written = out_reg_r;
  assign out_chan.halted_flag = out_halt_r;

endmodule

// File: tb/dcis_step_checker.sv
// ----------------------------------------------------------------------------
// dcis_step_checker
// Watches both channels of the decimal computer step, predicts each result
// word from its own copy of the machine and compares field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module dcis_step_checker
  import dcis_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  dcis_in_if   in_mon,
  dcis_out_if  out_mon,
  output int   fail_count,
  output int   words_pending
);

  typedef struct packed {
    ev_t                     ev;
    logic [CHAR_W-1:0]       ch;
    logic [ADDR_FIELD_W-1:0] pc;
    word_t                   iw;
    word_t                   rv;
    logic                    halt;
  } step_result_t;

  step_result_t expected_q[$];

  // machine image
  int mem_img [MEM_WORDS];
  int reg_img [REG_COUNT];
  int pc_img;
  int ir_img;
  bit halt_img;
  bit str_on;
  int str_at;

  int failures;
  int results_seen;

  assign fail_count = failures;

  task automatic report_failure(input string msg);
    $display("[%0t] result word %0d: %s", $realtime, results_seen, msg);
    failures++;
  endtask

  task automatic check_field(input string field, input logic signed [31:0] got,
                             input logic signed [31:0] want);
    if (got !== want) report_failure($sformatf("%s got %0d, expected %0d", field, got, want));
  endtask

  function automatic int magnitude(input int w);
    return (w < 0) ? -w : w;
  endfunction

  function automatic int reg_index(input int w);
    return ((magnitude(w) / 100) % 10) % REG_COUNT;
  endfunction

  function automatic void bump_pc();
    pc_img = (pc_img + 1) % MEM_WORDS;
  endfunction

  // one character of a print string; look ahead to see whether it ends
  function automatic ev_t emit_string_char(input int p, output int ch);
    ch = 0;
    if (p >= MEM_WORDS || mem_img[p] == 0) begin
      str_on = 1'b0;
      bump_pc();
      return EV_NONE;
    end
    ch = mem_img[p];
    p++;
    if (p >= MEM_WORDS || mem_img[p] == 0) begin
      str_on = 1'b0;
      bump_pc();
    end else begin
      str_on = 1'b1;
      str_at = p;
    end
    return EV_PRINT;
  endfunction

  function automatic step_result_t predict_word(input logic is_step,
                                                input logic [ADDR_FIELD_W-1:0] addr_in,
                                                input word_t value_in,
                                                input logic [CHAR_W-1:0] char_in);
    step_result_t res;
    int value, w, m, r, mm, target, imm, ch, rv;
    logic [DIGIT_W-1:0] op, sub;
    ev_t ev;
    res = '0;
    res.pc = ADDR_FIELD_W'(pc_img);
    ev = EV_NONE;
    ch = 0;
    rv = 0;
    if (!is_step) begin
      value = value_in;
      if (value > WORD_MAX) value = WORD_MAX;
      if (value < -WORD_MAX) value = -WORD_MAX;
      if (addr_in < MEM_WORDS) mem_img[addr_in] = value;
    end else if (halt_img) begin
      ev = EV_HALTED;
    end else if (str_on) begin
      ev = emit_string_char(str_at, ch);
      rv = reg_img[reg_index(ir_img)];
    end else begin
      w = mem_img[pc_img];
      ir_img = w;
      m = magnitude(w);
      op = DIGIT_W'(m / 1000);
      sub = DIGIT_W'((m / 100) % 10);
      r = reg_index(w);
      mm = m % 100;
      target = mm % MEM_WORDS;
      imm = (w < 0) ? -mm : mm;
      case (op)
        OP_HALT: begin
          halt_img = 1'b1;
          ev = EV_HALT;
        end
        OP_LOAD: begin
          reg_img[r] = mem_img[target];
          bump_pc();
        end
        OP_STORE: begin
          mem_img[target] = reg_img[r];
          bump_pc();
        end
        OP_ADD: begin
          reg_img[r] = (reg_img[r] + mem_img[target]) % MOD_BASE;
          bump_pc();
        end
        OP_NEG: begin
          reg_img[r] = -reg_img[r];
          bump_pc();
        end
        OP_LDI: begin
          reg_img[r] = imm;
          bump_pc();
        end
        OP_ADDI: begin
          reg_img[r] = (reg_img[r] + imm) % MOD_BASE;
          bump_pc();
        end
        OP_JMP: pc_img = target;
        OP_BPOS: begin
          if (reg_img[r] > 0) pc_img = target;
          else bump_pc();
        end
        default: begin
          case (sub)
            SUB_READ: begin
              reg_img[0] = char_in;
              ev = EV_READ;
              bump_pc();
            end
            SUB_PRINT: begin
              ch = reg_img[0];
              ev = EV_PRINT;
              bump_pc();
            end
            SUB_STRING: ev = emit_string_char(target, ch);
            default: bump_pc();
          endcase
        end
      endcase
      rv = reg_img[r];
    end
    res.ev = ev;
    res.ch = ch[CHAR_W-1:0];
    res.iw = word_t'(ir_img);
    res.rv = word_t'(rv);
    res.halt = halt_img;
    return res;
  endfunction

  always @(posedge clk) begin
    step_result_t want;
    if (!rst_n) begin
      foreach (mem_img[i]) mem_img[i] = 0;
      foreach (reg_img[i]) reg_img[i] = 0;
      pc_img = 0;
      ir_img = 0;
      halt_img = 1'b0;
      str_on = 1'b0;
      str_at = 0;
      expected_q.delete();
      failures = 0;
      results_seen = 0;
    end else begin
      if (in_mon.valid && in_mon.ready) begin
        expected_q.push_back(predict_word(in_mon.kind, in_mon.load_addr,
                                          in_mon.load_value, in_mon.char_in));
      end
      if (out_mon.valid && out_mon.ready) begin
        if (expected_q.size() == 0) begin
          report_failure($sformatf("arrived with nothing expected (event %0d)",
                                   out_mon.event_res));
        end else begin
          want = expected_q.pop_front();
          check_field("event_res", out_mon.event_res, want.ev);
          check_field("char_out", out_mon.char_out, want.ch);
          check_field("pc_now", out_mon.pc_now, want.pc);
          check_field("instr_word", out_mon.instr_word, want.iw);
          check_field("reg_written", out_mon.reg_written, want.rv);
          check_field("halted_flag", out_mon.halted_flag, want.halt);
        end
        results_seen++;
      end
    end
    words_pending <= expected_q.size();
  end

endmodule

// File: tb/tb_decimal_computer_instruction_step.sv
// ----------------------------------------------------------------------------
// tb_decimal_computer_instruction_step
// Drives load and step words into the decimal computer with random gaps and
// result stalls; a checker beside the block predicts and compares every
// result word. A short hand-built program comes first, then random programs
// kept inside a fenced code region, and finally a halt.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_decimal_computer_instruction_step;
  import dcis_pkg::*;

  localparam int CLK_HALF     = 5;
  localparam int RESET_CYCLES = 4;
  localparam int MAX_GAP      = 7;
  localparam int RANDOM_WORDS = 200;
  localparam int HALT_STEPS   = 30;
  localparam int DRAIN_CYCLES = 20;
  localparam int TIMEOUT_NS   = 2_000_000;

  // Random programs live in 0..PROG_LAST; FENCE_SLOT always holds a jump back
  // into that region, and stores only land in DATA_FIRST upwards, so a random
  // program never runs into a halt word before the closing part of the run.
  localparam int PROG_LAST  = 78;
  localparam int FENCE_SLOT = 79;
  localparam int DATA_FIRST = 80;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_STEP = 1'b1;

  logic clk;
  logic rst_n;
  bit   calm;
  int   fail_count;
  int   words_pending;

  dcis_in_if  in_chan ();
  dcis_out_if out_chan ();

  decimal_computer_instruction_step i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  dcis_step_checker i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_chan),
    .out_mon       (out_chan),
    .fail_count    (fail_count),
    .words_pending (words_pending)
  );

  initial clk = 1'b0;
  always #(CLK_HALF) clk = ~clk;

  // Offer one word: idle for a random number of cycles (none while calm),
  // then hold valid until the block takes the word.
  task automatic send_word(input logic kind, input logic [ADDR_FIELD_W-1:0] addr,
                           input word_t value, input logic [CHAR_W-1:0] ch);
    int gap;
    gap = calm ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid      <= 1'b1;
    in_chan.kind       <= kind;
    in_chan.load_addr  <= addr;
    in_chan.load_value <= value;
    in_chan.char_in    <= ch;
    do @(posedge clk); while (!(in_chan.valid && in_chan.ready));
  endtask

  // Write a memory word; the character field is don't-care, so randomise it.
  task automatic load_memory(input int addr, input int value);
    send_word(KIND_LOAD, ADDR_FIELD_W'(addr), word_t'(value), CHAR_W'($urandom_range(0, 255)));
  endtask

  // Run one instruction; address and value are ignored, so let them roam.
  task automatic run_step(input int ch);
    send_word(KIND_STEP, ADDR_FIELD_W'($urandom_range(0, 127)),
              word_t'($urandom_range(0, 32767)), CHAR_W'(ch));
  endtask

  // Build a random instruction that keeps the program inside its region.
  function automatic word_t random_instruction();
    int op, digit, mm;
    op = $urandom_range(1, 12);
    if (op > OP_IO) op = OP_IO;  // weight the I/O group, it hides three operations
    digit = $urandom_range(0, 9);
    mm = $urandom_range(0, 99);
    if (op == OP_STORE) mm = $urandom_range(DATA_FIRST, MEM_WORDS - 1);
    if (op == OP_JMP || op == OP_BPOS) mm = $urandom_range(0, PROG_LAST);
    if (op == OP_IO) begin
      digit = $urandom_range(0, 4);
      if (digit > SUB_STRING) digit = $urandom_range(SUB_STRING + 1, DIGIT_BASE - 1);
      // most strings start in the data area, a few walk through the code
      if (digit == SUB_STRING && $urandom_range(0, 7) != 0)
        mm = $urandom_range(DATA_FIRST, MEM_WORDS - 1);
    end
    return word_t'(($urandom_range(0, 1) ? -1 : 1) * (op * 1000 + digit * 100 + mm));
  endfunction

  // Result side: stall for a random number of cycles before each word, then
  // hold ready until a word is taken.
  initial begin
    int stall;
    out_chan.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      stall = calm ? 0 : $urandom_range(0, MAX_GAP);
      if (stall > 0) begin
        out_chan.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_chan.ready <= 1'b1;
      do @(posedge clk); while (!(out_chan.valid && out_chan.ready));
    end
  end

  initial begin
    int sel;
    calm = 1'b0;
    rst_n              <= 1'b0;
    in_chan.valid      <= 1'b0;
    in_chan.kind       <= KIND_LOAD;
    in_chan.load_addr  <= '0;
    in_chan.load_value <= '0;
    in_chan.char_in    <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- Hand-built program ------------------------------------------------
    load_memory(0, 16383);      // largest value saturates to 9999: unused I/O code
    load_memory(50, -10000);    // saturates to -9999
    load_memory(127, -16384);   // beyond memory: writes nothing
    load_memory(1, 1350);       // R3 <- M[50]
    load_memory(2, 3350);       // R3 <- R3 + M[50], sum wraps keeping its sign
    load_memory(3, 4300);       // negate R3
    load_memory(4, 6399);       // add immediate, carries past 9999
    load_memory(5, 2351);       // M[51] <- R3
    load_memory(6, -5247);      // negative word: R2 <- -47
    load_memory(7, 9000);       // read a character
    load_memory(8, 9100);       // print R0
    load_memory(9, 9251);       // print the string at 51
    load_memory(52, 98);
    load_memory(10, 8299);      // R2 not positive: branch falls through
    load_memory(11, -8399);     // R3 positive: branch to the top of memory
    load_memory(97, 72);
    load_memory(98, -191);      // negative word prints its low byte
    load_memory(99, 9297);      // string that runs off the end of memory
    repeat (7) run_step($urandom_range(0, 255));
    run_step(255);              // read the largest character
    run_step($urandom_range(0, 255));
    run_step($urandom_range(0, 255));  // string start, more to come
    load_memory(52, 0);         // cut the string short while it is running
    repeat (2) run_step($urandom_range(0, 255));
    // jump lands on 99; three characters, then the pc wraps to zero
    repeat (4) run_step($urandom_range(0, 255));

    // --- Random programs ---------------------------------------------------
    for (int a = 0; a <= PROG_LAST; a++) load_memory(a, random_instruction());
    load_memory(FENCE_SLOT, OP_JMP * 1000 + $urandom_range(0, PROG_LAST));
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      // switch between gappy phases and stretches with no idling at all
      if (n % 40 == 0) calm = ($urandom_range(0, 3) == 0);
      sel = $urandom_range(0, 19);
      if (sel < 14) begin
        run_step($urandom_range(0, 255));
      end else if (sel < 16) begin
        load_memory($urandom_range(0, PROG_LAST), random_instruction());
      end else if (sel == 16) begin
        load_memory(FENCE_SLOT, ($urandom_range(0, 1) ? -1 : 1) *
                    (OP_JMP * 1000 + $urandom_range(0, PROG_LAST)));
      end else if (sel < 19) begin
        // raw data: any 15-bit pattern, saturated by the block
        load_memory($urandom_range(DATA_FIRST, MEM_WORDS - 1),
                    word_t'($urandom_range(0, 32767)));
      end else begin
        load_memory($urandom_range(MEM_WORDS, 127), word_t'($urandom_range(0, 32767)));
      end
    end
    calm = 1'b0;

    // --- Halt ----------------------------------------------------------------
    // Halting is for good, so it closes the run: clear the code region, let
    // any running string finish, then halt and keep stepping a halted machine.
    for (int a = 0; a <= FENCE_SLOT; a++) load_memory(a, 0);
    repeat (HALT_STEPS) run_step($urandom_range(0, 255));

    in_chan.valid <= 1'b0;
    @(posedge clk);
    wait (words_pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Drop the run if the handshakes stop moving.
  initial begin
    #(TIMEOUT_NS);
    $display("Test completed with failures");
    $finish;
  end

endmodule
